>>> rtl/core/fgc_pkg.sv
// fgc_pkg: shared types and constants for the fasta gc window counter
// no dependencies; imported by every module of the block except fgc_ram
`timescale 1ns / 1ps
`default_nettype none

package fgc_pkg;

    // configuration register indexes
    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_SEQUENCE_LIMIT = 1'b1;

    // configuration reset values
    localparam logic [10:0] WINDOW_LENGTH_RST = 11'd100;
    localparam logic [31:0] SEQUENCE_LIMIT_RST = 32'hFFFF_FFFF;

    // text characters
    localparam logic [7:0] CH_HEADER = 8'h3E; // '>'
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_UPPER_FIRST = 8'h41;
    localparam logic [7:0] CH_UPPER_LAST = 8'h5A;
    localparam logic [7:0] CH_LOWER_FIRST = 8'h61;
    localparam logic [7:0] CH_LOWER_LAST = 8'h7A;
    localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

    // item operations
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // count reported for a window holding an unknown base
    localparam logic signed [11:0] GC_UNKNOWN = -12'sd1;

    // parser phase
    typedef enum logic [1:0] {
        PH_SEEK,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } t_phase;

    // input transaction
    typedef struct packed {
        logic       op;
        logic [7:0] symbol;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [31:0]        position;
        logic signed [11:0] gc_count;
        logic               last;
        logic               overflow;
    } t_out;

    // work handed from the front end to the window stage
    typedef struct packed {
        logic        res;      // produces a result
        logic        sub;      // ring entry read back and taken off the total
        logic        g;        // gc flag added to the total
        logic        unk;      // unknown base lies in this window
        logic        last;
        logic        overflow;
        logic [31:0] position;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/core/fgc_ram.sv
// fgc_ram: generic single-port-write, single-port-read ram, registered read
// read-first on a same-address access; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module fgc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/fgc_parse.sv
// fgc_parse: text parser, base counters, configuration registers, ring access issue
// depends on fgc_pkg; drives the ring ram and feeds fgc_window
`timescale 1ns / 1ps
`default_nettype none

module fgc_parse #(
    parameter int WINDOW_MAX = 1024,
    parameter int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fgc_pkg::t_in   i_in_data,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic           i_s1_free,
    output logic                o_iss_valid,
    output fgc_pkg::t_stage     o_iss,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic                o_ram_wdata,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr
);
    import fgc_pkg::*;

    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);

    t_phase        r_phase, n_phase;
    logic [31:0]   r_bases, n_bases;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_dp, n_dp;
    logic          r_unk_valid, n_unk_valid;
    logic [31:0]   r_unk_pos, n_unk_pos;
    logic [31:0]   r_drain_pos, n_drain_pos;
    logic          r_halted, n_halted;
    logic [10:0]   r_win_len;
    logic [31:0]   r_seq_limit;

    logic          accept;
    logic [7:0]    up;
    logic          is_gc, is_unk, is_letter;
    logic          is_base, is_ovf, is_cnt, is_strm, is_drn, drn_res;
    logic [WW-1:0] win;
    logic [31:0]   win32, wp32, rp32, strm_pos;
    logic [AW-1:0] rp, rp_next;

    // clamp the window length into 1 .. WINDOW_MAX
    always_comb begin
        if (r_win_len == 11'd0) begin
            win = WW'(1);
        end else if ({21'd0, r_win_len} > 32'(WINDOW_MAX)) begin
            win = WW'(WINDOW_MAX);
        end else begin
            win = WW'(r_win_len);
        end
    end

    // symbol classification
    always_comb begin
        up = i_in_data.symbol & CASE_FOLD_MASK;
        is_gc = (up == CH_G) || (up == CH_C);
        is_unk = !(is_gc || up == CH_A || up == CH_T);
        is_letter = i_in_data.symbol inside {[CH_UPPER_FIRST:CH_UPPER_LAST],
                                             [CH_LOWER_FIRST:CH_LOWER_LAST]};
    end

    // item decode
    always_comb begin
        is_base = !r_halted && (i_in_data.op == OP_TEXT) && (r_phase == PH_BODY)
                  && is_letter;
        is_ovf = is_base && (r_bases >= r_seq_limit);
        is_cnt = is_base && !is_ovf;
        win32 = 32'(win);
        is_strm = is_cnt && (r_bases >= win32);
        strm_pos = r_bases - win32;
        is_drn = !r_halted && (i_in_data.op == OP_DRAIN);
        drn_res = is_drn && (r_drain_pos < r_bases);
    end

    // ring pointers: the read pointer lags the write pointer by the window
    always_comb begin
        wp32 = 32'(r_wp);
        if (wp32 >= win32) begin
            rp32 = wp32 - win32;
        end else begin
            rp32 = wp32 + 32'(WINDOW_MAX) - win32;
        end
        rp = rp32[AW-1:0];
        rp_next = (rp == PTR_LAST) ? '0 : rp + AW'(1);
    end

    assign o_in_ready = i_s1_free;
    assign accept = i_in_valid && i_s1_free;

    // work handed to the window stage
    always_comb begin
        o_iss_valid = accept && (is_cnt || is_ovf || drn_res);
        o_iss.res = is_ovf || is_strm || drn_res;
        o_iss.sub = is_strm || drn_res;
        o_iss.g = is_cnt && is_gc;
        o_iss.overflow = is_ovf;
        o_iss.last = drn_res && (r_drain_pos + 32'd1 == r_bases);
        if (is_ovf) begin
            o_iss.position = r_bases;
        end else if (is_strm) begin
            o_iss.position = strm_pos;
        end else begin
            o_iss.position = r_drain_pos;
        end
        if (is_strm) begin
            o_iss.unk = is_unk || (r_unk_valid && r_unk_pos > strm_pos);
        end else begin
            o_iss.unk = drn_res && r_unk_valid && (r_unk_pos > r_drain_pos);
        end
    end

    // ring write of the new base, ring read of the base leaving the window
    always_comb begin
        o_ram_we = accept && is_cnt;
        o_ram_waddr = r_wp;
        o_ram_wdata = is_gc;
        o_ram_re = accept && (is_strm || drn_res);
        o_ram_raddr = is_strm ? rp : r_dp;
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_bases = r_bases;
        n_wp = r_wp;
        n_dp = r_dp;
        n_unk_valid = r_unk_valid;
        n_unk_pos = r_unk_pos;
        n_drain_pos = r_drain_pos;
        n_halted = r_halted;
        if (accept && !r_halted) begin
            if (i_in_data.op == OP_DRAIN) begin
                n_phase = PH_DONE;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (i_in_data.symbol == CH_HEADER) n_phase = PH_HEADER;
                    end
                    PH_HEADER: begin
                        if (i_in_data.symbol == CH_NEWLINE) n_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        if (i_in_data.symbol == CH_HEADER) n_phase = PH_DONE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            if (is_ovf) begin
                n_halted = 1'b1;
            end
            if (is_cnt) begin
                n_bases = r_bases + 32'd1;
                n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + AW'(1);
                if (is_unk) begin
                    n_unk_valid = 1'b1;
                    n_unk_pos = r_bases;
                end
            end
            if (is_strm) begin
                n_drain_pos = strm_pos + 32'd1;
                n_dp = rp_next;
            end else if (drn_res) begin
                n_drain_pos = r_drain_pos + 32'd1;
                n_dp = (r_dp == PTR_LAST) ? '0 : r_dp + AW'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_bases <= '0;
            r_wp <= '0;
            r_dp <= '0;
            r_unk_valid <= 1'b0;
            r_unk_pos <= '0;
            r_drain_pos <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bases <= n_bases;
            r_wp <= n_wp;
            r_dp <= n_dp;
            r_unk_valid <= n_unk_valid;
            r_unk_pos <= n_unk_pos;
            r_drain_pos <= n_drain_pos;
            r_halted <= n_halted;
        end
    end

    // configuration registers; the window is frozen once a base is counted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WINDOW_LENGTH_RST;
            r_seq_limit <= SEQUENCE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: begin
                    if (r_bases == 32'd0 && !r_halted) r_win_len <= i_cfg_data[10:0];
                end
                CFG_SEQUENCE_LIMIT: begin
                    r_seq_limit <= i_cfg_data;
                end
                default: begin
                    r_seq_limit <= r_seq_limit;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fgc_window.sv
// fgc_window: ring read-back stage, running gc total and output register
// depends on fgc_pkg; takes work from fgc_parse and read data from the ring ram
`timescale 1ns / 1ps
`default_nettype none

module fgc_window #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    output logic                 o_s1_free,
    input  wire logic            i_iss_valid,
    input  wire fgc_pkg::t_stage i_iss,
    input  wire logic            i_rdata,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output fgc_pkg::t_out        o_out_data
);
    import fgc_pkg::*;

    localparam int WW = $clog2(WINDOW_MAX + 1);

    logic          r_s1_valid;
    t_stage        r_s1;
    logic [WW-1:0] r_total;
    logic          r_out_valid;
    t_out          r_out;
    logic          s1_adv;
    logic [WW-1:0] total_new;

    // stage advances unless its result is blocked by a stalled output
    assign s1_adv = r_s1_valid && (!r_s1.res || !r_out_valid || i_out_ready);
    assign o_s1_free = !r_s1_valid || s1_adv;

    // running total: drop the leaving base, add the new one
    assign total_new = r_total - WW'(r_s1.sub && i_rdata) + WW'(r_s1.g);

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_iss_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss_valid) begin
            r_s1 <= i_iss;
        end
    end

    // gc total register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (s1_adv) begin
            r_total <= total_new;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.res) begin
            r_out.position <= r_s1.position;
            r_out.last <= r_s1.last;
            r_out.overflow <= r_s1.overflow;
            if (r_s1.overflow) begin
                r_out.gc_count <= '0;
            end else if (r_s1.unk) begin
                r_out.gc_count <= GC_UNKNOWN;
            end else begin
                r_out.gc_count <= 12'(total_new);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> rtl/core/fasta_gc_window_counter.sv
// fasta_gc_window_counter: top level of the gc sliding window counter
// depends on fgc_pkg, fgc_parse, fgc_window and fgc_ram
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - input channel (i_in_valid / o_in_ready / i_in_data): one fasta text byte
//   or a drain request per transaction; text before the first '>' and the
//   header line are skipped, letters of the body count as bases
// - output channel (o_out_valid / i_out_ready / o_out_data): one result per
//   completed window, per drain with a pending position, or on overflow
// - configuration port (i_cfg_we / i_cfg_index / i_cfg_data): window length
//   and sequence limit, written while the block is idle
// - throughput: one transaction per cycle while o_in_ready is high; a counted
//   base costs a ring write, a completed window or drain a ring read of the
//   flag ram; the running total updates in the stage after the registered read
// - result path: a transaction is registered in the stage register, then its
//   result in the output register
// - stall: with the output held the stage behind it keeps taking transactions
//   until one that produces a result waits there, then o_in_ready drops until
//   the output register is taken
// - reset: synchronous, active low; clears parser, counters and totals at once;
//   the ring ram is not cleared since only written entries are ever read
// - after an overflow result the block ignores every transaction until reset
module fasta_gc_window_counter #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fgc_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fgc_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import fgc_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic          s1_free;
    logic          iss_valid;
    t_stage        iss;
    logic          ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    // parser and ring access issue
    fgc_parse #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s1_free   (s1_free),
        .o_iss_valid (iss_valid),
        .o_iss       (iss),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // gc flag ring
    fgc_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // total and output stage
    fgc_window #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_s1_free   (s1_free),
        .i_iss_valid (iss_valid),
        .i_iss       (iss),
        .i_rdata     (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/fgc_checker.sv
// fgc_checker: port-level assertions for the gc window counter, bound to the top
// depends on fgc_pkg and fasta_gc_window_counter
`timescale 1ns / 1ps
`default_nettype none

module fgc_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire fgc_pkg::t_out o_out_data
);
    import fgc_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // the block halts after an overflow result is taken
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.overflow) |=> !o_out_valid)
        else $error("result after overflow");

    // overflow results carry a zero count and no last mark
    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (o_out_data.gc_count == 12'sd0 && !o_out_data.last))
        else $error("bad overflow result");

    // count never below the unknown marker
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.gc_count >= GC_UNKNOWN))
        else $error("gc count out of range");

endmodule

bind fasta_gc_window_counter fgc_checker u_fgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> verif/fasta_gc_window_counter_test.sv
// fasta_gc_window_counter_test: self-checking bench for the fasta gc window counter
// holds its own window model, drives text and drain transactions, checks every result
// depends on fgc_pkg and fasta_gc_window_counter
`timescale 1ns / 1ps

module fasta_gc_window_counter_test;
    import fgc_pkg::*;

    localparam int WINDOW_MAX = 1024;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_WINDOW_LENGTH;
    logic [31:0] cfg_data = '0;

    // traffic shaping
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic out_hold = 1'b0;
    logic stall_armed = 1'b0;

    // bookkeeping
    int errors = 0;
    int results_checked = 0;
    int items_queued = 0;
    int items_taken = 0;

    t_in  text_pending [$];
    t_out gc_expected [$];

    // window model state
    logic [10:0] win_reg;
    logic [31:0] base_limit;
    t_phase      parse_ph;
    logic [31:0] bases_counted;
    bit          gc_ring [WINDOW_MAX];
    logic [11:0] gc_total;
    logic        unk_seen;
    logic [31:0] unk_pos;
    logic [31:0] drain_next;
    logic        halted_m;

    fasta_gc_window_counter #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= CH_UPPER_FIRST && c <= CH_UPPER_LAST) ||
               (c >= CH_LOWER_FIRST && c <= CH_LOWER_LAST);
    endfunction

    // count reported for position p, unknown base in its window wins
    function automatic logic signed [11:0] window_count(logic [31:0] p);
        if (unk_seen && unk_pos > p) begin
            return GC_UNKNOWN;
        end
        return gc_total;
    endfunction

    // one accepted transaction through the model, expectation queued if any
    task automatic advance_gc_model(t_in item);
        t_out        r;
        logic [31:0] n;
        logic [31:0] w;
        logic [7:0]  up;
        logic        g;
        r = '0;
        if (halted_m) begin
            return;
        end
        if (item.op == OP_DRAIN) begin
            parse_ph = PH_DONE;
            if (drain_next < bases_counted) begin
                gc_total = gc_total - gc_ring[drain_next % WINDOW_MAX];
                r.position = drain_next;
                r.gc_count = window_count(drain_next);
                r.last = (drain_next + 32'd1 == bases_counted);
                gc_expected.push_back(r);
                drain_next = drain_next + 32'd1;
            end
            return;
        end
        case (parse_ph)
            PH_SEEK: begin
                if (item.symbol == CH_HEADER) begin
                    parse_ph = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (item.symbol == CH_NEWLINE) begin
                    parse_ph = PH_BODY;
                end
            end
            PH_BODY: begin
                if (item.symbol == CH_HEADER) begin
                    parse_ph = PH_DONE;
                end else if (is_letter(item.symbol)) begin
                    n = bases_counted;
                    w = {21'd0, win_reg};
                    if (w == 0) begin
                        w = 1;
                    end else if (w > WINDOW_MAX) begin
                        w = WINDOW_MAX;
                    end
                    up = item.symbol & CASE_FOLD_MASK;
                    g = (up == CH_G || up == CH_C);
                    if (n >= base_limit) begin
                        // base past the limit: overflow result, then silence
                        halted_m = 1'b1;
                        r.position = n;
                        r.overflow = 1'b1;
                        gc_expected.push_back(r);
                    end else begin
                        if (n >= w) begin
                            gc_total = gc_total - gc_ring[(n - w) % WINDOW_MAX];
                        end
                        gc_ring[n % WINDOW_MAX] = g;
                        gc_total = gc_total + g;
                        if (!g && up != CH_A && up != CH_T) begin
                            unk_seen = 1'b1;
                            unk_pos = n;
                        end
                        bases_counted = n + 32'd1;
                        if (n >= w) begin
                            r.position = n - w;
                            r.gc_count = window_count(n - w);
                            gc_expected.push_back(r);
                            drain_next = n - w + 32'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic flag_mismatch(string msg);
        if (errors < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (gc_expected.size() == 0) begin
            flag_mismatch($sformatf("result for position %0d with nothing expected",
                                    got.position));
            return;
        end
        want = gc_expected.pop_front();
        results_checked++;
        if (got.position !== want.position) begin
            flag_mismatch($sformatf("position %0d, expected %0d", got.position, want.position));
        end
        if (got.gc_count !== want.gc_count) begin
            flag_mismatch($sformatf("gc_count %0d at position %0d, expected %0d",
                                    got.gc_count, want.position, want.gc_count));
        end
        if (got.last !== want.last) begin
            flag_mismatch($sformatf("last %b at position %0d, expected %b",
                                    got.last, want.position, want.last));
        end
        if (got.overflow !== want.overflow) begin
            flag_mismatch($sformatf("overflow %b at position %0d, expected %b",
                                    got.overflow, want.position, want.overflow));
        end
    endtask

    task automatic push_item(logic op, logic [7:0] sym);
        t_in it;
        it.op = op;
        it.symbol = sym;
        text_pending.push_back(it);
        items_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(OP_TEXT, s[i]);
        end
    endtask

    // mostly bases, a few unknown letters and some ignored bytes, never '>'
    function automatic logic [7:0] body_symbol();
        string      bases = "ACGTacgt";
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 999);
        if (r < 870) begin
            b = bases[$urandom_range(0, 7)];
        end else if (r < 880) begin
            b = ($urandom_range(0, 1) != 0) ? "N" : "n";
        end else if (r < 910) begin
            b = ($urandom_range(0, 1) != 0) ? CH_UPPER_FIRST + 8'($urandom_range(0, 25))
                                            : CH_LOWER_FIRST + 8'($urandom_range(0, 25));
        end else begin
            b = 8'($urandom_range(0, 255));
            if (is_letter(b) || b == CH_HEADER) begin
                b = b | 8'h80;
            end
        end
        return b;
    endfunction

    task automatic push_body(int count);
        for (int i = 0; i < count; i++) begin
            push_item(OP_TEXT, body_symbol());
        end
    endtask

    // register write while idle; the model follows at the same edge
    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH) begin
            if (bases_counted == 0 && !halted_m) begin
                win_reg = val[10:0];
            end
        end else begin
            base_limit = val;
        end
    endtask

    // wait until every transaction is taken and every result has arrived
    task automatic wait_quiet();
        while (items_taken != items_queued || gc_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver: offer the next pending transaction, model it on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                advance_gc_model(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (text_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= text_pending.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transaction, randomise ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_result(out_data);
        end
        out_ready <= !out_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (stall_armed);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("fasta_gc_window_counter_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        int   w_sel;
        int   k;
        int   n_drain;
        logic drain_end;

        // model reset state
        win_reg = WINDOW_LENGTH_RST;
        base_limit = SEQUENCE_LIMIT_RST;
        parse_ph = PH_SEEK;
        bases_counted = '0;
        gc_total = '0;
        unk_seen = 1'b0;
        unk_pos = '0;
        drain_next = '0;
        halted_m = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct <= 30;
        recv_idle_pct <= 81;

        // register extremes, then the window used for this run
        write_reg(CFG_WINDOW_LENGTH, 32'd2047);
        write_reg(CFG_SEQUENCE_LIMIT, 32'd1);
        write_reg(CFG_WINDOW_LENGTH, 32'd0);
        w_sel = $urandom_range(0, 7);
        case (w_sel)
            0: write_reg(CFG_WINDOW_LENGTH, 32'd0);
            1: write_reg(CFG_WINDOW_LENGTH, 32'd1);
            2: write_reg(CFG_WINDOW_LENGTH, 32'd2047);
            3: write_reg(CFG_WINDOW_LENGTH, 32'd1024);
            default: write_reg(CFG_WINDOW_LENGTH, $urandom_range(2, 64));
        endcase
        write_reg(CFG_SEQUENCE_LIMIT, SEQUENCE_LIMIT_RST);

        // directed: junk before the marker, header with a stray '>', then
        // every base in both cases, unknown letters and ignored bytes
        push_item(OP_TEXT, 8'hFF);
        push_text("A>>");
        push_item(OP_TEXT, 8'h80);
        push_item(OP_TEXT, CH_NEWLINE);
        push_text("AcGtaCgTNx@[{");
        push_item(OP_TEXT, 8'h60);
        push_item(OP_TEXT, 8'hFF);
        push_item(OP_TEXT, CH_NEWLINE);
        wait_quiet();

        // window rewrite after the first base must be ignored
        write_reg(CFG_WINDOW_LENGTH, $urandom());
        push_body(280);
        wait_quiet();

        // swap idling, with a long output hold at the start
        write_reg(CFG_SEQUENCE_LIMIT, bases_counted + 32'd5000);
        send_idle_pct <= 81;
        recv_idle_pct <= 30;
        stall_armed <= 1'b1;
        push_body(280);
        wait_quiet();

        // no idling
        write_reg(CFG_SEQUENCE_LIMIT, SEQUENCE_LIMIT_RST);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        push_body(280);
        wait_quiet();

        // finish the sequence by draining or by running into the limit
        drain_end = ($urandom_range(0, 1) != 0);
        if (drain_end) begin
            if ($urandom_range(0, 1) != 0) begin
                push_item(OP_TEXT, CH_HEADER);
            end
            n_drain = bases_counted - drain_next + 3;
            for (int i = 0; i < n_drain; i++) begin
                push_item(OP_DRAIN, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) begin
                    push_item(OP_TEXT, body_symbol());
                end
            end
            wait_quiet();
        end else begin
            k = $urandom_range(0, 3);
            write_reg(CFG_SEQUENCE_LIMIT, bases_counted + k);
            for (int i = 0; i <= k; i++) begin
                push_item(OP_TEXT, CH_UPPER_FIRST + 8'($urandom_range(0, 25)));
            end
            for (int i = 0; i < 12; i++) begin
                if ($urandom_range(0, 1) != 0) begin
                    push_item(OP_DRAIN, 8'($urandom_range(0, 255)));
                end else begin
                    push_item(OP_TEXT, body_symbol());
                end
            end
            wait_quiet();
            // halted: writes and transactions change nothing
            write_reg(CFG_WINDOW_LENGTH, 32'd1024);
            write_reg(CFG_SEQUENCE_LIMIT, SEQUENCE_LIMIT_RST);
            push_item(OP_DRAIN, 8'h00);
            push_text("GC");
            wait_quiet();
        end

        $display("run covered %0d transactions, %0d bases, window setting %0d, %0d results checked",
                 items_taken, bases_counted, win_reg, results_checked);
        $display("sequence closed by %s", drain_end ? "drain requests" : "sequence limit overflow");
        if (errors == 0) begin
            $display("fasta_gc_window_counter_test: done, clean");
        end else begin
            $display("fasta_gc_window_counter_test: done, errors");
        end
        $finish;
    end

endmodule
